>>> rtl/core/cmst_pkg.sv
//==============================================================================
// cmst_pkg
// Shared types and constants for the column statistics core.
//==============================================================================
`default_nettype none
package cmst_pkg;

  localparam int SUM_W   = 40;
  localparam int SQ_W    = 62;
  localparam int CNT_W   = 17;
  localparam int COL_W   = 4;
  localparam int NCOL_W  = 5;
  localparam int K_W     = 16;
  localparam int MEAN_W  = 24;
  localparam int SD_W    = 23;
  localparam int PROD_W  = 80;  // N*sumsq and sum^2 both fit
  localparam int ROOT_W  = 41;

  localparam logic [0:0] REG_NUM_COLUMNS = 1'd0;
  localparam logic [0:0] REG_K_FACTOR    = 1'd1;

  // item passed from the front end to the back end
  typedef struct packed {
    logic              acc;     // sample goes into a column
    logic [COL_W-1:0]  col;
    logic signed [23:0] smp;
    logic              last;
  } cmst_cmd_t;

endpackage
`default_nettype wire

>>> rtl/core/cmst_front.sv
//==============================================================================
// cmst_front
// Accepts input transactions, classifies them and queues them as commands.
//==============================================================================
`default_nettype none
module cmst_front
  import cmst_pkg::*;
#(
  parameter int SAMPLE_WIDTH = 24
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [23:0]      in_sample,
  input  wire logic [COL_W-1:0] in_col,
  input  wire logic             in_last,
  input  wire logic [NCOL_W:0]  ncol,     // effective column count
  output logic                  q_valid,
  input  wire logic             q_ready,
  output cmst_cmd_t             q_cmd
);

  localparam int DEPTH = 4;

  cmst_cmd_t   mem [DEPTH];
  logic [1:0]  wr_ptr, rd_ptr;
  logic [2:0]  fill;
  logic        push, pop;
  cmst_cmd_t   cmd;
  logic signed [23:0] sx;

  always_comb begin
    sx = 24'(signed'(in_sample[SAMPLE_WIDTH-1:0]));
    cmd.acc  = ({2'b00, in_col} < ncol);
    cmd.col  = in_col;
    cmd.smp  = sx;
    cmd.last = in_last;
  end

  assign in_ready = (fill != 3'(DEPTH));
  assign push     = in_valid && in_ready;
  assign q_valid  = (fill != 3'd0);
  assign pop      = q_valid && q_ready;
  assign q_cmd    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 2'd1;
      if (pop)  rd_ptr <= rd_ptr + 2'd1;
      fill <= fill + 3'(push) - 3'(pop);
    end
  end

  assert property (@(posedge clk) disable iff (rst) fill <= 3'(DEPTH))
    else $error("queue overfilled");
  assert property (@(posedge clk) disable iff (rst) (fill == 3'd0) |-> !pop)
    else $error("pop from empty queue");
  assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (fill == $past(fill) + 3'd1))
    else $error("fill count wrong");

endmodule
`default_nettype wire

>>> rtl/core/cmst_back.sv
//==============================================================================
// cmst_back
// Accumulates per-column sums; on a last command runs mean, sqrt and
// threshold per column through shared multi-cycle units and emits results.
//==============================================================================
`default_nettype none
module cmst_back
  import cmst_pkg::*;
#(
  parameter int MAX_ROWS = 65536
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              q_valid,
  output logic                   q_ready,
  input  cmst_cmd_t              q_cmd,
  input  wire logic [NCOL_W:0]   ncol,
  input  wire logic signed [K_W-1:0] kf,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [COL_W-1:0]       o_col,
  output logic signed [MEAN_W-1:0] o_mean,
  output logic [SD_W-1:0]        o_sd,
  output logic signed [MEAN_W-1:0] o_thr,
  output logic [CNT_W-1:0]       o_cnt,
  output logic                   o_sat,
  output logic                   o_last
);

  typedef enum logic [9:0] {
    S_ACC   = 10'b0000000001,
    S_RD    = 10'b0000000010,
    S_MUL   = 10'b0000000100,
    S_SQRT  = 10'b0000001000,
    S_DIV   = 10'b0000010000,
    S_THR   = 10'b0000100000,
    S_OUT   = 10'b0001000000,
    S_CLR   = 10'b0010000000,
    S_MULH  = 10'b0100000000,
    S_MULL  = 10'b1000000000
  } state_t;

  state_t state;

  logic signed [SUM_W-1:0] sum_r [16];
  logic [SQ_W-1:0]         sq_r  [16];
  logic [CNT_W-1:0]        cnt_r [16];

  logic [COL_W-1:0]  col;
  logic [SQ_W-1:0]   s_sq;
  logic [CNT_W-1:0]  s_cnt;
  logic [SUM_W-1:0]  amag;
  logic [PROD_W-1:0] p_acc, q_acc, rad;
  logic [PROD_W+1:0] rad_ext;
  logic [5:0]        step;
  logic [ROOT_W-1:0] root;
  logic [ROOT_W+2:0] sq_rem;
  logic [PROD_W-1:0] rem;
  logic [ROOT_W-1:0] quo;      // quotient of division
  logic [SUM_W-1:0]  mquo;
  logic [SUM_W-1:0]  mrem;
  logic              sum_neg;
  logic signed [MEAN_W-1:0] mean_r;
  logic [SD_W-1:0]   sd_r;

  logic signed [47:0] sq_in;
  logic [47:0]        sq_mag;
  logic               fire;
  logic [CNT_W-1:0]   max_rows;
  logic [4:0]         col_last;

  assign max_rows = CNT_W'(MAX_ROWS);
  assign col_last = 5'(ncol - 6'd1);
  assign q_ready  = (state == S_ACC);
  assign fire     = q_valid && q_ready;
  assign sq_in    = 48'(q_cmd.smp) * 48'(q_cmd.smp);
  assign sq_mag   = 48'(sq_in);

  // threshold
  logic signed [SD_W+K_W+1:0] kprod;
  logic signed [49:0] full, thr_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_ACC;
      out_valid <= 1'b0;
      col       <= '0;
      step      <= '0;
      for (int i = 0; i < 16; i++) begin
        sum_r[i] <= '0;
        sq_r[i]  <= '0;
        cnt_r[i] <= '0;
      end
    end else begin
      unique case (state)
        S_ACC: begin
          if (fire) begin
            if (q_cmd.acc && cnt_r[q_cmd.col] < max_rows) begin
              sum_r[q_cmd.col] <= sum_r[q_cmd.col] + SUM_W'(q_cmd.smp);
              sq_r[q_cmd.col]  <= sq_r[q_cmd.col] + SQ_W'(sq_mag);
              cnt_r[q_cmd.col] <= cnt_r[q_cmd.col] + CNT_W'(1);
            end
            if (q_cmd.last) begin
              col   <= '0;
              state <= S_RD;
            end
          end
        end
        S_RD: begin
          s_sq    <= sq_r[col];
          s_cnt   <= cnt_r[col];
          sum_neg <= sum_r[col][SUM_W-1];
          amag    <= sum_r[col][SUM_W-1] ? SUM_W'(-sum_r[col]) : SUM_W'(sum_r[col]);
          state   <= S_MUL;
        end
        S_MUL: begin
          // N (17b) times sumsq (62b): split sumsq into halves
          p_acc <= PROD_W'(PROD_W'(s_cnt) * PROD_W'(s_sq[30:0]));
          state <= S_MULH;
        end
        S_MULH: begin
          p_acc <= p_acc + (PROD_W'(PROD_W'(s_cnt) * PROD_W'(s_sq[SQ_W-1:31])) << 31);
          q_acc <= PROD_W'(PROD_W'(amag[19:0]) * PROD_W'(amag));
          state <= S_MULL;
        end
        S_MULL: begin
          q_acc  <= q_acc + (PROD_W'(PROD_W'(amag[SUM_W-1:20]) * PROD_W'(amag)) << 20);
          state  <= S_SQRT;
          step   <= 6'd40;
          root   <= '0;
          sq_rem <= '0;
        end
        S_SQRT: begin
          // digit-by-digit root, two radicand bits per cycle
          logic [ROOT_W+2:0] r_try, t_try;
          r_try = {sq_rem[ROOT_W:0], rad_ext[{step, 1'b0} +: 2]};
          t_try = {1'b0, root, 2'b01};
          if (r_try >= t_try) begin
            sq_rem <= r_try - t_try;
            root   <= {root[ROOT_W-2:0], 1'b1};
          end else begin
            sq_rem <= r_try;
            root   <= {root[ROOT_W-2:0], 1'b0};
          end
          if (step == 6'd0) begin
            state <= S_DIV;
            step  <= 6'd40;
            rem   <= '0;
            mrem  <= '0;
          end else begin
            step <= step - 6'd1;
          end
        end
        S_DIV: begin
          // one quotient bit per cycle for sd=root/N and |mean|=|sum|/N
          logic [PROD_W-1:0] r1;
          logic [SUM_W:0]    r2;
          r1 = {rem[PROD_W-2:0], root[step[5:0]]};
          r2 = {mrem, (step < 6'd40) ? amag[step[5:0]] : 1'b0};
          if (r1 >= PROD_W'(s_cnt)) begin
            rem <= r1 - PROD_W'(s_cnt);
            quo[step[5:0]] <= 1'b1;
          end else begin
            rem <= r1;
            quo[step[5:0]] <= 1'b0;
          end
          if (step < 6'd40) begin
            if (r2 >= (SUM_W+1)'(s_cnt)) begin
              mrem <= SUM_W'(r2 - (SUM_W+1)'(s_cnt));
              mquo[step[5:0]] <= 1'b1;
            end else begin
              mrem <= SUM_W'(r2);
              mquo[step[5:0]] <= 1'b0;
            end
          end
          if (step == 6'd0) state <= S_THR;
          else step <= step - 6'd1;
        end
        S_THR: begin
          mean_r <= sum_neg ? MEAN_W'(-mquo) : MEAN_W'(mquo);
          sd_r   <= (quo > ROOT_W'(23'h7FFFFF)) ? 23'h7FFFFF : SD_W'(quo);
          state  <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid) begin
            out_valid <= 1'b1;
            o_col  <= col;
            o_cnt  <= s_cnt;
            o_last <= ({1'b0, col} == col_last);
            if (s_cnt == '0) begin
              o_mean <= '0; o_sd <= '0; o_thr <= '0; o_sat <= 1'b0;
            end else begin
              o_mean <= mean_r;
              o_sd   <= sd_r;
              if (thr_q > 50'sd8388607) begin
                o_thr <= 24'sh7FFFFF; o_sat <= 1'b1;
              end else if (thr_q < -50'sd8388608) begin
                o_thr <= 24'sh800000; o_sat <= 1'b1;
              end else begin
                o_thr <= MEAN_W'(thr_q); o_sat <= 1'b0;
              end
            end
          end else if (out_ready) begin
            out_valid <= 1'b0;
            if ({1'b0, col} == col_last) begin
              state <= S_CLR;
            end else begin
              col   <= col + COL_W'(1);
              state <= S_RD;
            end
          end
        end
        S_CLR: begin
          for (int i = 0; i < 16; i++) begin
            sum_r[i] <= '0;
            sq_r[i]  <= '0;
            cnt_r[i] <= '0;
          end
          state <= S_ACC;
        end
        default: state <= S_ACC;
      endcase
    end
  end

  assign rad     = (q_acc <= p_acc) ? p_acc - q_acc : '0;
  assign rad_ext = {2'b00, rad};
  assign kprod   = (SD_W+K_W+2)'(kf) * (SD_W+K_W+2)'($signed({1'b0, sd_r}));
  assign full    = (50'(mean_r) <<< 8) + 50'(kprod);
  assign thr_q   = full >>> 8;

  assert property (@(posedge clk) disable iff (rst) out_valid |-> (state == S_OUT))
    else $error("result shown outside output state");
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped while stalled");
  assert property (@(posedge clk) disable iff (rst) (state != S_ACC) |-> !q_ready)
    else $error("command taken during result run");

endmodule
`default_nettype wire

>>> rtl/core/column_mean_stddev_threshold_core.sv
// A sample enters the queue when accepted and is summed when the back end takes it.
// Throughput: one sample per cycle while accumulating; a 4-entry queue absorbs stalls.
// A last sample then runs each configured column through read, three multiply states,
// a 41-step sqrt and divide, threshold, output (may stall); input stalls once the queue fills.
// Reset (synchronous, rst high) clears sums, counts, queue and registers
// num_columns=1, k gain=3.0.
//==============================================================================
// column_mean_stddev_threshold_core
// Per-column mean, standard deviation and threshold over streamed samples.
//==============================================================================
`default_nettype none
module column_mean_stddev_threshold_core
  import cmst_pkg::*;
#(
  parameter int MAX_ROWS     = 65536,
  parameter int SAMPLE_WIDTH = 24
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // sample[23:0], column[27:24], zeros
  input  wire logic        s_tlast,   // last_sample
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [95:0]      m_tdata,   // result_column, mean_value, std_deviation,
                                      // threshold, row_count, zeros
  output logic [0:0]       m_tuser,   // threshold_saturated
  output logic             m_tlast,   // last_result
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  logic [NCOL_W-1:0]   num_columns;
  logic signed [K_W-1:0] k_gain;
  logic [NCOL_W:0]     ncol;
  logic                q_valid, q_ready;
  cmst_cmd_t           q_cmd;
  logic [COL_W-1:0]    o_col;
  logic signed [MEAN_W-1:0] o_mean, o_thr;
  logic [SD_W-1:0]     o_sd;
  logic [CNT_W-1:0]    o_cnt;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_columns <= 5'd1;
      k_gain      <= 16'sd768;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_NUM_COLUMNS: num_columns <= cfg_data[NCOL_W-1:0];
        REG_K_FACTOR:    k_gain      <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (num_columns == '0)        ncol = 6'd1;
    else if (num_columns > 5'd16) ncol = 6'd16;
    else                          ncol = {1'b0, num_columns};
  end

  cmst_front #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_front (
    .clk, .rst,
    .in_valid (s_tvalid), .in_ready (s_tready),
    .in_sample(s_tdata[23:0]), .in_col(s_tdata[27:24]), .in_last(s_tlast),
    .ncol, .q_valid, .q_ready, .q_cmd
  );

  cmst_back #(.MAX_ROWS(MAX_ROWS)) u_back (
    .clk, .rst, .q_valid, .q_ready, .q_cmd, .ncol, .kf(k_gain),
    .out_valid(m_tvalid), .out_ready(m_tready),
    .o_col, .o_mean, .o_sd, .o_thr, .o_cnt, .o_sat(m_tuser[0]), .o_last(m_tlast)
  );

  assign m_tdata = {4'd0, o_cnt, o_thr, o_sd, o_mean, o_col};

endmodule
`default_nettype wire
